>>> hw/rtl/glb_pkg.sv
// glb_pkg: shared types and constants for the glyph bitmap lookup unit.
// No dependencies; imported by the channel interfaces and all glb modules.
package glb_pkg;

	// payload widths
	localparam int OP_W       = 2;
	localparam int CODE_W     = 32;
	localparam int SLOT_W     = 8;
	localparam int OFFSET_W   = 9;
	localparam int BYTE_W     = 8;
	localparam int WORD_BYTES = 8;
	localparam int WORD_W     = WORD_BYTES * BYTE_W;
	localparam int BYTE_SEL_W = 3;
	localparam int BCNT_W     = 4;

	// configuration registers
	localparam int COUNT_W    = 9;
	localparam int ROWS_W     = 6;
	localparam int COLS_W     = 5;
	localparam int AREA_W     = ROWS_W + COLS_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_ROWS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_COLS   = 2'd2;

	// operations
	localparam logic [OP_W-1:0] OP_LOAD_CODE = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_BYTE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP    = 2'd2;

	// result status
	localparam logic STATUS_FOUND = 1'b0;
	localparam logic STATUS_MISS  = 1'b1;

	// one byte write into the bitmap word memory
	typedef struct packed {
		logic                  en;
		logic [BYTE_SEL_W-1:0] lane;
		logic [BYTE_W-1:0]     data;
	} byte_wr_t;

	// one result beat
	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] glyph_index;
		logic [WORD_W-1:0] pixel_bytes;
		logic [BCNT_W-1:0] byte_count;
		logic              last;
	} rsp_t;

endpackage

>>> hw/rtl/glb_ifs.sv
// glb_ifs: valid/ready channel interfaces for commands and result beats.
// Depends on glb_pkg.
interface glb_cmd_if import glb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [CODE_W-1:0]   code;
	logic [SLOT_W-1:0]   slot;
	logic [OFFSET_W-1:0] offset;
	logic [BYTE_W-1:0]   data_byte;

	modport source (output valid, operation, code, slot, offset, data_byte, input ready);
	modport sink   (input valid, operation, code, slot, offset, data_byte, output ready);
endinterface

interface glb_rsp_if import glb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              status;
	logic [SLOT_W-1:0] glyph_index;
	logic [WORD_W-1:0] pixel_bytes;
	logic [BCNT_W-1:0] byte_count;
	logic              last;

	modport source (output valid, status, glyph_index, pixel_bytes, byte_count, last,
		input ready);
	modport sink   (input valid, status, glyph_index, pixel_bytes, byte_count, last,
		output ready);
endinterface

>>> hw/rtl/glb_bitmap_ram.sv
// glb_bitmap_ram: bitmap store as 8-byte words, byte-lane write, registered read.
// Depends on glb_pkg (byte_wr_t, word widths).
module glb_bitmap_ram import glb_pkg::*; #(
	parameter int ADDR_W = 14,
	parameter int DEPTH  = 16384
) (
	input  logic              clk,
	input  byte_wr_t          wr,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr][wr.lane*BYTE_W +: BYTE_W] <= wr.data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hw/rtl/glyph_bitmap_lookup_unit.sv
// glyph_bitmap_lookup_unit: top level; sorted code table, binary search sequencer,
// bitmap word streaming. Depends on glb_pkg, glb_ifs, glb_bitmap_ram.
//
//  channel  dir  handshake            beat content
//  cmd      in   cmd.valid/cmd.ready  operation, code, slot, offset, data_byte
//  rsp      out  rsp.valid/rsp.ready  status, glyph_index, pixel_bytes, byte_count, last
//  cfg      in   cfg_we (no stall)    cfg_index, cfg_data
//
// Loads (code entry, bitmap byte) and unused operations leave the unit idle.
// A lookup holds cmd.ready low until its last beat is in the output register:
// ST_PROBE and ST_CMP for each probe of the shared 32-bit compare (up to
// ceil(log2(count+1)) probes, nine at most), ST_READ for the RAM read, then one
// ST_STREAM beat per 8-byte word (up to 64); a zero-size cell goes from its hit probe
// to ST_SINGLE, a miss from its last probe via ST_PROBE (empty-interval check) to
// ST_SINGLE. rsp stalls hold the beat states; the output register lets a new command in
// while the last beat still waits. arst_n clears state, config and rsp.valid.
module glyph_bitmap_lookup_unit import glb_pkg::*; #(
	parameter int MAX_GLYPHS     = 256,
	parameter int MAX_CELL_BYTES = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	glb_cmd_if.sink               cmd,
	glb_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// table index, search bound, words per cell, cell length widths
	localparam int GW        = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int CW        = $clog2(MAX_GLYPHS + 1);
	localparam int WPC       = (MAX_CELL_BYTES + WORD_BYTES - 1) / WORD_BYTES;
	localparam int WW        = (WPC > 1) ? $clog2(WPC) : 1;
	localparam int LEN_W     = $clog2(MAX_CELL_BYTES + 1);
	localparam int RAM_AW    = GW + WW;
	localparam int RAM_DEPTH = MAX_GLYPHS * (1 << WW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_READ,
		ST_STREAM,
		ST_SINGLE
	} state_t;

	// configuration registers
	logic [COUNT_W-1:0] glyph_count_q;
	logic [ROWS_W-1:0]  cell_rows_q;
	logic [COLS_W-1:0]  cell_cols_q;

	// sequencer
	state_t            state_q;
	logic [CODE_W-1:0] key_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;
	logic [GW-1:0]     mid_q;
	logic [GW-1:0]     idx_q;
	logic [LEN_W-1:0]  len_q;
	logic [WW-1:0]     word_q;
	logic              status_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	// code table
	logic [CODE_W-1:0] code_mem [MAX_GLYPHS];
	logic [CODE_W-1:0] tbl_rd_q;

	logic              cmd_fire;
	logic              slot_ok;
	logic [GW-1:0]     slot_idx;
	logic [CW-1:0]     hi_init;
	logic [CW:0]       mid_sum;
	logic [GW-1:0]     mid;
	logic              lo_lt_hi;
	logic              key_eq;
	logic              key_lt;
	logic [AREA_W-1:0] cell_area;
	logic [LEN_W-1:0]  cell_len;
	logic [LEN_W-1:0]  pos;
	logic [LEN_W-1:0]  rem;
	logic              last_word;
	logic [BCNT_W-1:0] nbytes;
	logic [WORD_W-1:0] masked;
	logic              rsp_free;
	logic              rsp_load;
	byte_wr_t          bm_wr;
	logic [RAM_AW-1:0] bm_wr_addr;
	logic              bm_rd_en;
	logic [RAM_AW-1:0] bm_rd_addr;
	logic [WORD_W-1:0] bm_rd_data;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	// a new beat enters the output register this cycle
	assign rsp_load  = rsp_free && ((state_q == ST_STREAM) || (state_q == ST_SINGLE));

	assign slot_ok  = 32'(cmd.slot) < 32'(MAX_GLYPHS);
	assign slot_idx = GW'(cmd.slot);

	// search bound saturates at the table depth
	always_comb begin
		if (32'(glyph_count_q) > 32'(MAX_GLYPHS)) begin
			hi_init = CW'(MAX_GLYPHS);
		end else begin
			hi_init = CW'(glyph_count_q);
		end
	end

	assign mid_sum  = (CW + 1)'(lo_q) + (CW + 1)'(hi_q);
	assign mid      = GW'(mid_sum[CW:1]);
	assign lo_lt_hi = lo_q < hi_q;

	// the shared unsigned compare
	assign key_eq = (key_q == tbl_rd_q);
	assign key_lt = (key_q < tbl_rd_q);

	// cell size, saturated to the per-slot store
	assign cell_area = AREA_W'(cell_rows_q) * AREA_W'(cell_cols_q);
	assign cell_len  = (32'(cell_area) > 32'(MAX_CELL_BYTES)) ? LEN_W'(MAX_CELL_BYTES)
		: LEN_W'(cell_area);

	// word slicing for the stream
	assign pos       = LEN_W'({word_q, {BYTE_SEL_W{1'b0}}});
	assign rem       = len_q - pos;
	assign last_word = 32'(rem) <= 32'(WORD_BYTES);
	assign nbytes    = last_word ? BCNT_W'(rem) : BCNT_W'(WORD_BYTES);

	always_comb begin
		for (int b = 0; b < WORD_BYTES; b++) begin
			if (BCNT_W'(b) < nbytes) begin
				masked[b*BYTE_W +: BYTE_W] = bm_rd_data[b*BYTE_W +: BYTE_W];
			end else begin
				masked[b*BYTE_W +: BYTE_W] = '0;
			end
		end
	end

	// bitmap write port
	always_comb begin
		bm_wr.en   = cmd_fire && (cmd.operation == OP_LOAD_BYTE) && slot_ok
			&& (32'(cmd.offset) < 32'(MAX_CELL_BYTES));
		bm_wr.lane = cmd.offset[BYTE_SEL_W-1:0];
		bm_wr.data = cmd.data_byte;
	end
	assign bm_wr_addr = {slot_idx, WW'(cmd.offset >> BYTE_SEL_W)};

	// first word read in ST_READ, then one word ahead while streaming
	assign bm_rd_en   = (state_q == ST_READ)
		|| ((state_q == ST_STREAM) && rsp_free && !last_word);
	assign bm_rd_addr = {idx_q, (state_q == ST_READ) ? word_q : WW'(word_q + 1'b1)};

	glb_bitmap_ram #(
		.ADDR_W (RAM_AW),
		.DEPTH  (RAM_DEPTH)
	) u_bitmap_ram (
		.clk     (clk),
		.wr      (bm_wr),
		.wr_addr (bm_wr_addr),
		.rd_en   (bm_rd_en),
		.rd_addr (bm_rd_addr),
		.rd_data (bm_rd_data)
	);

	// code table: written by code loads, read at the probe index
	always_ff @(posedge clk) begin
		if (cmd_fire && (cmd.operation == OP_LOAD_CODE) && slot_ok) begin
			code_mem[slot_idx] <= cmd.code;
		end
		if ((state_q == ST_PROBE) && lo_lt_hi) begin
			tbl_rd_q <= code_mem[mid];
		end
	end

	// configuration writes; index 3 is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= '0;
			cell_rows_q   <= '0;
			cell_cols_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GLYPH_COUNT: glyph_count_q <= COUNT_W'(cfg_data);
				CFG_CELL_ROWS:   cell_rows_q   <= ROWS_W'(cfg_data);
				CFG_CELL_COLS:   cell_cols_q   <= COLS_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// search / stream sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			idx_q       <= '0;
			len_q       <= '0;
			word_q      <= '0;
			status_q    <= STATUS_FOUND;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// register empties when taken, refills when a beat is loaded
			if (rsp_free) begin
				rsp_valid_q <= rsp_load;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire && (cmd.operation == OP_LOOKUP)) begin
						key_q   <= cmd.code;
						lo_q    <= '0;
						hi_q    <= hi_init;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (lo_lt_hi) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else begin
						status_q <= STATUS_MISS;
						state_q  <= ST_SINGLE;
					end
				end
				ST_CMP: begin
					if (key_eq) begin
						idx_q  <= mid_q;
						len_q  <= cell_len;
						word_q <= '0;
						if (cell_len == '0) begin
							status_q <= STATUS_FOUND;
							state_q  <= ST_SINGLE;
						end else begin
							state_q <= ST_READ;
						end
					end else begin
						if (key_lt) begin
							hi_q <= CW'(mid_q);
						end else begin
							lo_q <= CW'(mid_q) + 1'b1;
						end
						state_q <= ST_PROBE;
					end
				end
				ST_READ: begin
					state_q <= ST_STREAM;
				end
				ST_STREAM: begin
					if (rsp_free) begin
						rsp_q.status      <= STATUS_FOUND;
						rsp_q.glyph_index <= SLOT_W'(idx_q);
						rsp_q.pixel_bytes <= masked;
						rsp_q.byte_count  <= nbytes;
						rsp_q.last        <= last_word;
						if (last_word) begin
							state_q <= ST_IDLE;
						end else begin
							word_q <= WW'(word_q + 1'b1);
						end
					end
				end
				ST_SINGLE: begin
					// miss, or hit on a zero-size cell
					if (rsp_free) begin
						rsp_q.status      <= status_q;
						rsp_q.glyph_index <= (status_q == STATUS_FOUND) ? SLOT_W'(idx_q) : '0;
						rsp_q.pixel_bytes <= '0;
						rsp_q.byte_count  <= '0;
						rsp_q.last        <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.glyph_index = rsp_q.glyph_index;
	assign rsp.pixel_bytes = rsp_q.pixel_bytes;
	assign rsp.byte_count  = rsp_q.byte_count;
	assign rsp.last        = rsp_q.last;

`ifndef SYNTHESIS
	// a probe is only compared when the interval was non-empty
	a_cmp_interval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (lo_q < hi_q))
		else $error("compare state with empty search interval");

	a_miss_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == STATUS_MISS)) |->
		(rsp.last && (rsp.byte_count == '0) && (rsp.pixel_bytes == '0)
		&& (rsp.glyph_index == '0)))
		else $error("miss beat carries payload");

	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == STATUS_FOUND) && !rsp.last) |->
		(rsp.byte_count == BCNT_W'(WORD_BYTES)))
		else $error("short word before the last beat");

	a_lookup_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && (cmd.operation == OP_LOOKUP)) |=>
		((state_q == ST_PROBE) && !cmd.ready))
		else $error("lookup did not start the search");

	a_stream_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_STREAM) || (state_q == ST_READ)) |-> (len_q != '0))
		else $error("streaming a zero-size cell");
`endif

endmodule
